FILE: hdl/assert_macros.svh
// Assertion helpers for the calculator modules.
// Every module that uses them has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on aclk, masked while reset is held.
`define ASSERT_AT_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Same, with a message of the caller's choosing.
`define ASSERT_AT_CLK_MSG(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`endif

FILE: hdl/ltrc_pkg.sv
`timescale 1ns / 1ps

package ltrc_pkg;

    localparam int VALUE_WIDTH  = 48;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_SYMBOLS  = 99;
    localparam int SYMBOL_WIDTH = 8;
    localparam int DIGIT_WIDTH  = 4;
    localparam int ERR_WIDTH    = 2;
    localparam int COUNT_WIDTH  = $clog2(MAX_SYMBOLS + 1);
    // divide runs one quotient bit per step over VALUE_WIDTH + FRAC_BITS bits
    localparam int ITER_WIDTH   = $clog2(VALUE_WIDTH + FRAC_BITS + 1);

    typedef logic [VALUE_WIDTH-1:0]  value_t;
    typedef logic [SYMBOL_WIDTH-1:0] symbol_t;
    typedef logic [ERR_WIDTH-1:0]    err_t;
    typedef logic [2:0]              op_t;
    typedef logic [2:0]              dp_op_t;

    localparam symbol_t CHAR_NEWLINE = 8'h0A;
    localparam symbol_t CHAR_MUL     = 8'h2A;
    localparam symbol_t CHAR_ADD     = 8'h2B;
    localparam symbol_t CHAR_SUB     = 8'h2D;
    localparam symbol_t CHAR_DIV     = 8'h2F;
    localparam symbol_t CHAR_ZERO    = 8'h30;
    localparam symbol_t CHAR_NINE    = 8'h39;

    localparam op_t OP_NONE = 3'd0;
    localparam op_t OP_MUL  = 3'd1;
    localparam op_t OP_ADD  = 3'd2;
    localparam op_t OP_SUB  = 3'd3;
    localparam op_t OP_DIV  = 3'd4;

    localparam err_t ERR_OK       = 2'd0;
    localparam err_t ERR_DIV_ZERO = 2'd1;
    localparam err_t ERR_OVERFLOW = 2'd2;

    // datapath commands
    localparam dp_op_t DP_NOP   = 3'd0;
    localparam dp_op_t DP_CLEAR = 3'd1;
    localparam dp_op_t DP_DIGIT = 3'd2;
    localparam dp_op_t DP_LOAD  = 3'd3;
    localparam dp_op_t DP_ADD   = 3'd4;
    localparam dp_op_t DP_SUB   = 3'd5;
    localparam dp_op_t DP_MUL   = 3'd6;
    localparam dp_op_t DP_DIV   = 3'd7;

    typedef struct packed {
        dp_op_t                 op;
        logic                   to_opnd;
        logic [DIGIT_WIDTH-1:0] digit;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_sts_t;

endpackage

FILE: hdl/ltrc_dp.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ltrc_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  ltrc_pkg::dp_cmd_t  cmd,
    output ltrc_pkg::dp_sts_t  sts,
    output ltrc_pkg::value_t   acc,
    output ltrc_pkg::err_t     err
);

    localparam int W  = ltrc_pkg::VALUE_WIDTH;
    localparam int F  = ltrc_pkg::FRAC_BITS;
    localparam int NW = W + F;
    localparam int PW = 2 * W;
    localparam int IW = ltrc_pkg::ITER_WIDTH;

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

    ltrc_pkg::value_t acc_reg, acc_next;
    ltrc_pkg::value_t opnd_reg, opnd_next;
    ltrc_pkg::value_t x_reg, x_next;
    ltrc_pkg::value_t y_reg, y_next;
    ltrc_pkg::err_t   err_reg, err_next;

    logic [PW-1:0] prod_reg, prod_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  mc_reg, mc_next;
    logic          neg_reg, neg_next;
    logic          div_mode_reg, div_mode_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    logic          x_neg, y_neg;
    logic [W-1:0]  x_mag, y_mag;
    logic [W-1:0]  tgt, tgt_mag, x10_mag, x10_val, digit_val;
    logic          tgt_neg, tgt_ovf;
    logic [W+3:0]  tgt_x10, tgt_lim;
    logic [W:0]    x_ext, y_ext, sum;
    logic          sum_ovf;
    logic [W-1:0]  sum_val;
    logic [W:0]    mul_sum, trial, div_diff;
    logic          div_ge;
    logic [PW-1:0] fin_mag, fin_lim;
    logic          fin_ovf;
    logic [W-1:0]  fin_m, fin_val;
    logic          raise, clear_err;
    ltrc_pkg::err_t code;
    logic          err_hold;

    // sign / magnitude views
    always_comb begin
        x_neg   = x_reg[W-1];
        y_neg   = y_reg[W-1];
        x_mag   = x_neg ? (~x_reg + 1'b1) : x_reg;
        y_mag   = y_neg ? (~y_reg + 1'b1) : y_reg;
        tgt     = cmd.to_opnd ? opnd_reg : acc_reg;
        tgt_neg = tgt[W-1];
        tgt_mag = tgt_neg ? (~tgt + 1'b1) : tgt;
    end

    // digit step, first half: v * 10 saturated on the magnitude
    always_comb begin
        tgt_x10   = ({4'b0000, tgt_mag} << 3) + ({4'b0000, tgt_mag} << 1);
        tgt_lim   = tgt_neg ? {4'b0000, MIN_NEG} : {4'b0000, MAX_POS};
        tgt_ovf   = tgt_x10 > tgt_lim;
        x10_mag   = tgt_ovf ? tgt_lim[W-1:0] : tgt_x10[W-1:0];
        x10_val   = tgt_neg ? (~x10_mag + 1'b1) : x10_mag;
        digit_val = W'(cmd.digit) << F;
    end

    // saturating add / subtract
    always_comb begin
        x_ext   = {x_reg[W-1], x_reg};
        y_ext   = {y_reg[W-1], y_reg};
        sum     = (cmd.op == ltrc_pkg::DP_SUB) ? (x_ext - y_ext) : (x_ext + y_ext);
        sum_ovf = sum[W] ^ sum[W-1];
        sum_val = sum_ovf ? (sum[W] ? MIN_NEG : MAX_POS) : sum[W-1:0];
    end

    // iterative multiply / divide steps and final saturation
    always_comb begin
        mul_sum  = {1'b0, prod_reg[PW-1:W]} + (prod_reg[0] ? {1'b0, mc_reg} : {(W+1){1'b0}});
        trial    = {rem_reg, quo_reg[NW-1]};
        div_ge   = trial >= {1'b0, mc_reg};
        div_diff = trial - {1'b0, mc_reg};
        fin_mag  = div_mode_reg ? PW'(quo_reg) : (prod_reg >> F);
        fin_lim  = neg_reg ? PW'(MIN_NEG) : PW'(MAX_POS);
        fin_ovf  = fin_mag > fin_lim;
        fin_m    = fin_ovf ? fin_lim[W-1:0] : fin_mag[W-1:0];
        fin_val  = neg_reg ? (~fin_m + 1'b1) : fin_m;
    end

    always_comb begin
        acc_next      = acc_reg;
        opnd_next     = opnd_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        prod_next     = prod_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        mc_next       = mc_reg;
        neg_next      = neg_reg;
        div_mode_next = div_mode_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        raise         = 1'b0;
        code          = ltrc_pkg::ERR_OVERFLOW;
        clear_err     = 1'b0;

        if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_next = cnt_reg - 1'b1;
                if (div_mode_reg) begin
                    rem_next = div_ge ? div_diff[W-1:0] : trial[W-1:0];
                    quo_next = {quo_reg[NW-2:0], div_ge};
                end else begin
                    prod_next = {mul_sum, prod_reg[W-1:1]};
                end
            end else begin
                acc_next  = fin_val;
                raise     = fin_ovf;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else begin
            case (cmd.op)
                ltrc_pkg::DP_CLEAR: begin
                    acc_next  = '0;
                    opnd_next = '0;
                    clear_err = 1'b1;
                end
                ltrc_pkg::DP_DIGIT: begin
                    x_next = x10_val;
                    y_next = digit_val;
                    raise  = tgt_ovf;
                end
                ltrc_pkg::DP_LOAD: begin
                    x_next    = acc_reg;
                    y_next    = opnd_reg;
                    opnd_next = '0;
                end
                ltrc_pkg::DP_ADD, ltrc_pkg::DP_SUB: begin
                    if (cmd.to_opnd) begin
                        opnd_next = sum_val;
                    end else begin
                        acc_next = sum_val;
                    end
                    raise = sum_ovf;
                end
                ltrc_pkg::DP_MUL: begin
                    mc_next       = x_mag;
                    prod_next     = {{W{1'b0}}, y_mag};
                    neg_next      = x_neg ^ y_neg;
                    div_mode_next = 1'b0;
                    cnt_next      = IW'(W);
                    busy_next     = 1'b1;
                end
                ltrc_pkg::DP_DIV: begin
                    if (y_reg == '0) begin
                        acc_next  = x_neg ? MIN_NEG : MAX_POS;
                        raise     = 1'b1;
                        code      = ltrc_pkg::ERR_DIV_ZERO;
                        done_next = 1'b1;
                    end else begin
                        mc_next       = y_mag;
                        quo_next      = NW'(x_mag) << F;
                        rem_next      = '0;
                        neg_next      = x_neg ^ y_neg;
                        div_mode_next = 1'b1;
                        cnt_next      = IW'(NW);
                        busy_next     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // first error of an expression sticks
        if (clear_err) begin
            err_next = ltrc_pkg::ERR_OK;
        end else if (raise && err_reg == ltrc_pkg::ERR_OK) begin
            err_next = code;
        end else begin
            err_next = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            opnd_reg <= '0;
            err_reg  <= ltrc_pkg::ERR_OK;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            acc_reg  <= acc_next;
            opnd_reg <= opnd_next;
            err_reg  <= err_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        mc_reg       <= mc_next;
        neg_reg      <= neg_next;
        div_mode_reg <= div_mode_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc      = acc_reg;
    assign err      = err_reg;

    assign err_hold = (err_reg != ltrc_pkg::ERR_OK) && (cmd.op != ltrc_pkg::DP_CLEAR);

    `ASSERT_AT_CLK_MSG(a_done_pulse, done_reg |=> !done_reg, "done held two cycles")
    `ASSERT_AT_CLK(a_busy_not_done, !(busy_reg && done_reg))
    `ASSERT_AT_CLK_MSG(a_err_sticky, err_hold |=> err_reg == $past(err_reg), "error overwritten")

endmodule

FILE: hdl/ltrc_ctrl.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ltrc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ltrc_pkg::symbol_t   s_symbol,
    input  logic                out_free,
    output logic                emit,
    output ltrc_pkg::dp_cmd_t   cmd,
    input  ltrc_pkg::dp_sts_t   sts
);

    localparam int CW = ltrc_pkg::COUNT_WIDTH;
    localparam logic [CW-1:0] MAX_COUNT = CW'(ltrc_pkg::MAX_SYMBOLS);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DIGIT_ADD = 3'd1;
    localparam logic [2:0] ST_APPLY     = 3'd2;
    localparam logic [2:0] ST_WAIT      = 3'd3;
    localparam logic [2:0] ST_EMIT      = 3'd4;

    logic [2:0]        state_reg, state_next;
    ltrc_pkg::op_t     pending_reg, pending_next;
    ltrc_pkg::op_t     new_op_reg, new_op_next;
    logic              after_op_reg, after_op_next;
    logic              newline_reg, newline_next;
    logic [CW-1:0]     count_reg, count_next;

    logic              accept, is_newline, is_digit, count_full, finish_apply;
    ltrc_pkg::op_t     sym_op;
    ltrc_pkg::symbol_t sym_diff;

    always_comb begin
        is_newline = s_symbol == ltrc_pkg::CHAR_NEWLINE;
        is_digit   = (s_symbol >= ltrc_pkg::CHAR_ZERO) && (s_symbol <= ltrc_pkg::CHAR_NINE);
        sym_diff   = s_symbol - ltrc_pkg::CHAR_ZERO;
        count_full = count_reg >= MAX_COUNT;
        case (s_symbol)
            ltrc_pkg::CHAR_MUL: sym_op = ltrc_pkg::OP_MUL;
            ltrc_pkg::CHAR_ADD: sym_op = ltrc_pkg::OP_ADD;
            ltrc_pkg::CHAR_SUB: sym_op = ltrc_pkg::OP_SUB;
            ltrc_pkg::CHAR_DIV: sym_op = ltrc_pkg::OP_DIV;
            default:            sym_op = ltrc_pkg::OP_NONE;
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        new_op_next   = new_op_reg;
        after_op_next = after_op_reg;
        newline_next  = newline_reg;
        count_next    = count_reg;
        finish_apply  = 1'b0;
        emit          = 1'b0;
        cmd.op        = ltrc_pkg::DP_NOP;
        cmd.to_opnd   = after_op_reg;
        cmd.digit     = sym_diff[ltrc_pkg::DIGIT_WIDTH-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_newline) begin
                        newline_next = 1'b1;
                        if (pending_reg != ltrc_pkg::OP_NONE) begin
                            cmd.op     = ltrc_pkg::DP_LOAD;
                            state_next = ST_APPLY;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end else if ((is_digit || sym_op != ltrc_pkg::OP_NONE) && !count_full) begin
                        count_next = count_reg + 1'b1;
                        if (is_digit) begin
                            cmd.op     = ltrc_pkg::DP_DIGIT;
                            state_next = ST_DIGIT_ADD;
                        end else begin
                            newline_next = 1'b0;
                            new_op_next  = sym_op;
                            if (pending_reg != ltrc_pkg::OP_NONE) begin
                                cmd.op     = ltrc_pkg::DP_LOAD;
                                state_next = ST_APPLY;
                            end else begin
                                pending_next  = sym_op;
                                after_op_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DIGIT_ADD: begin
                cmd.op     = ltrc_pkg::DP_ADD;
                state_next = ST_IDLE;
            end
            ST_APPLY: begin
                cmd.to_opnd = 1'b0;
                case (pending_reg)
                    ltrc_pkg::OP_ADD: begin
                        cmd.op       = ltrc_pkg::DP_ADD;
                        finish_apply = 1'b1;
                    end
                    ltrc_pkg::OP_SUB: begin
                        cmd.op       = ltrc_pkg::DP_SUB;
                        finish_apply = 1'b1;
                    end
                    ltrc_pkg::OP_MUL: begin
                        cmd.op     = ltrc_pkg::DP_MUL;
                        state_next = ST_WAIT;
                    end
                    ltrc_pkg::OP_DIV: begin
                        cmd.op     = ltrc_pkg::DP_DIV;
                        state_next = ST_WAIT;
                    end
                    default: begin
                        finish_apply = 1'b1;
                    end
                endcase
            end
            ST_WAIT: begin
                finish_apply = sts.done;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    cmd.op        = ltrc_pkg::DP_CLEAR;
                    pending_next  = ltrc_pkg::OP_NONE;
                    after_op_next = 1'b0;
                    newline_next  = 1'b0;
                    count_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // pending operator done: either close the expression or arm the new one
        if (finish_apply) begin
            if (newline_reg) begin
                state_next = ST_EMIT;
            end else begin
                pending_next  = new_op_reg;
                after_op_next = 1'b1;
                state_next    = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pending_reg  <= ltrc_pkg::OP_NONE;
            new_op_reg   <= ltrc_pkg::OP_NONE;
            after_op_reg <= 1'b0;
            newline_reg  <= 1'b0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            new_op_reg   <= new_op_next;
            after_op_reg <= after_op_next;
            newline_reg  <= newline_next;
            count_reg    <= count_next;
        end
    end

    `ASSERT_AT_CLK_MSG(a_count_bound, count_reg <= MAX_COUNT, "symbol count past limit")
    `ASSERT_AT_CLK(a_after_op_match, after_op_reg == (pending_reg != ltrc_pkg::OP_NONE))
    `ASSERT_AT_CLK(a_wait_has_unit, (state_reg == ST_WAIT) |-> (sts.busy || sts.done))

endmodule

FILE: hdl/left_to_right_calculator.sv
`timescale 1ns / 1ps

// Left-to-right calculator, one ASCII character per s_ transaction.
// s_symbol: digits build numbers, '*' '+' '-' '/' apply the pending operator
// with no precedence, newline closes the expression; other characters are
// dropped. Each newline yields one m_ transaction: m_value (signed fixed point,
// FRAC_BITS fraction bits) and m_error_code (first error: div by zero/overflow).
// Per character: an ignored character or a bare operator needs only the accept;
// a digit adds the digit-add state, an operator or newline with a pending
// operator adds the apply state, and a pending '*' or '/' then waits in the
// wait state for the shift-add / restoring-divide unit ('/' by zero skips the unit).
// A newline then passes through the emit state, which loads the result
// register and raises m_valid once the output is free.
// One character is in work at a time; s_ready is high only when idle.
// The result register lets the next expression start while m_valid waits.
// If the receiver stalls and a second result is ready, the block holds it
// and keeps s_ready low until the first is taken.
// Reset (aresetn low, synchronous) clears the expression state and m_valid.

module left_to_right_calculator (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic [ltrc_pkg::SYMBOL_WIDTH-1:0]           s_symbol,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic signed [ltrc_pkg::VALUE_WIDTH-1:0]     m_value,
    output logic [ltrc_pkg::ERR_WIDTH-1:0]              m_error_code
);

    ltrc_pkg::dp_cmd_t cmd;
    ltrc_pkg::dp_sts_t sts;
    ltrc_pkg::value_t  acc;
    ltrc_pkg::err_t    err;
    logic              emit, out_free;

    logic                                    m_valid_reg, m_valid_next;
    logic signed [ltrc_pkg::VALUE_WIDTH-1:0] m_value_reg;
    ltrc_pkg::err_t                          m_error_code_reg;

    ltrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_symbol (s_symbol),
        .out_free (out_free),
        .emit     (emit),
        .cmd      (cmd),
        .sts      (sts)
    );

    ltrc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .acc     (acc),
        .err     (err)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_value_reg      <= acc;
            m_error_code_reg <= err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_error_code = m_error_code_reg;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET     = 1450;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT  = 3000;

    localparam int VW = ltrc_pkg::VALUE_WIDTH;
    localparam int FB = ltrc_pkg::FRAC_BITS;

    localparam ltrc_pkg::value_t VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam ltrc_pkg::value_t VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [127:0] POS_LIMIT = 128'(VALUE_MAX);
    localparam logic [127:0] NEG_LIMIT = 128'(VALUE_MIN);

    typedef struct {
        ltrc_pkg::value_t value;
        ltrc_pkg::err_t   code;
    } calc_result_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [ltrc_pkg::SYMBOL_WIDTH-1:0]     s_symbol;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [VW-1:0]                  m_value;
    logic [ltrc_pkg::ERR_WIDTH-1:0]        m_error_code;

    // expression state of the predictor
    ltrc_pkg::value_t acc_q;
    ltrc_pkg::value_t opnd_q;
    ltrc_pkg::op_t    pend_op;
    bit               seen_op;
    int               sym_count;
    ltrc_pkg::err_t   err_held;

    calc_result_t predicted_results[$];
    int mismatches;
    int symbols_sent;
    int idle_cycles;
    bit sender_burst;
    bit receiver_burst;
    bit hold_off_request;

    left_to_right_calculator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_error_code (m_error_code)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic void clear_expression();
        acc_q     = '0;
        opnd_q    = '0;
        pend_op   = ltrc_pkg::OP_NONE;
        seen_op   = 1'b0;
        sym_count = 0;
        err_held  = ltrc_pkg::ERR_OK;
    endfunction

    function automatic logic [127:0] magnitude_of(ltrc_pkg::value_t v);
        ltrc_pkg::value_t m;
        m = v[VW-1] ? -v : v;
        return 128'(m);
    endfunction

    // clamp a sign/magnitude pair into range, first error wins
    function automatic ltrc_pkg::value_t saturate_value(bit neg, logic [127:0] mag);
        logic [127:0] lim;
        ltrc_pkg::value_t r;
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        if (mag > lim) begin
            if (err_held == ltrc_pkg::ERR_OK) err_held = ltrc_pkg::ERR_OVERFLOW;
            mag = lim;
        end
        r = mag[VW-1:0];
        return neg ? -r : r;
    endfunction

    function automatic ltrc_pkg::value_t sum_sat(ltrc_pkg::value_t a, ltrc_pkg::value_t b,
                                                 bit subtract);
        logic signed [VW+1:0] s;
        logic [VW+1:0] m;
        s = subtract ? $signed(a) - $signed(b) : $signed(a) + $signed(b);
        m = s[VW+1] ? -s : s;
        return saturate_value(s[VW+1], 128'(m));
    endfunction

    function automatic ltrc_pkg::value_t product_sat(ltrc_pkg::value_t a, ltrc_pkg::value_t b);
        logic [127:0] p;
        p = (magnitude_of(a) * magnitude_of(b)) >> FB;
        return saturate_value(a[VW-1] ^ b[VW-1], p);
    endfunction

    function automatic ltrc_pkg::value_t quotient_sat(ltrc_pkg::value_t a, ltrc_pkg::value_t b);
        logic [127:0] mb;
        logic [127:0] q;
        mb = magnitude_of(b);
        if (mb == 0) begin
            if (err_held == ltrc_pkg::ERR_OK) err_held = ltrc_pkg::ERR_DIV_ZERO;
            return a[VW-1] ? VALUE_MIN : VALUE_MAX;
        end
        q = (magnitude_of(a) << FB) / mb;
        return saturate_value(a[VW-1] ^ b[VW-1], q);
    endfunction

    function automatic ltrc_pkg::value_t digit_append(ltrc_pkg::value_t v, logic [3:0] d);
        ltrc_pkg::value_t t;
        ltrc_pkg::value_t step;
        step = VW'(d) << FB;
        t = saturate_value(v[VW-1], magnitude_of(v) * 10);
        return sum_sat(t, step, 1'b0);
    endfunction

    function automatic void apply_pending();
        case (pend_op)
            ltrc_pkg::OP_MUL: acc_q = product_sat(acc_q, opnd_q);
            ltrc_pkg::OP_ADD: acc_q = sum_sat(acc_q, opnd_q, 1'b0);
            ltrc_pkg::OP_SUB: acc_q = sum_sat(acc_q, opnd_q, 1'b1);
            ltrc_pkg::OP_DIV: acc_q = quotient_sat(acc_q, opnd_q);
            default: ;
        endcase
        opnd_q = '0;
    endfunction

    function automatic void predict_symbol(ltrc_pkg::symbol_t c);
        ltrc_pkg::op_t op;
        ltrc_pkg::symbol_t diff;
        logic [3:0] d;
        calc_result_t r;
        op = ltrc_pkg::OP_NONE;
        diff = c - ltrc_pkg::CHAR_ZERO;
        d = diff[3:0];
        if (c == ltrc_pkg::CHAR_NEWLINE) begin
            apply_pending();
            r.value = acc_q;
            r.code  = err_held;
            predicted_results.push_back(r);
            clear_expression();
            return;
        end
        case (c)
            ltrc_pkg::CHAR_MUL: op = ltrc_pkg::OP_MUL;
            ltrc_pkg::CHAR_ADD: op = ltrc_pkg::OP_ADD;
            ltrc_pkg::CHAR_SUB: op = ltrc_pkg::OP_SUB;
            ltrc_pkg::CHAR_DIV: op = ltrc_pkg::OP_DIV;
            default: if (c < ltrc_pkg::CHAR_ZERO || c > ltrc_pkg::CHAR_NINE) return;
        endcase
        if (sym_count >= ltrc_pkg::MAX_SYMBOLS) return;
        sym_count++;
        if (op == ltrc_pkg::OP_NONE) begin
            if (seen_op) opnd_q = digit_append(opnd_q, d);
            else acc_q = digit_append(acc_q, d);
        end else begin
            apply_pending();
            pend_op = op;
            seen_op = 1'b1;
        end
    endfunction

    task automatic send_symbol(input ltrc_pkg::symbol_t sym);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_symbol <= sym;
        do @(posedge aclk); while (!s_ready);
        predict_symbol(sym);
        symbols_sent++;
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++) send_symbol(text[i]);
        send_symbol(ltrc_pkg::CHAR_NEWLINE);
    endtask

    function automatic ltrc_pkg::symbol_t pick_operator();
        case ($urandom_range(0, 3))
            0: return ltrc_pkg::CHAR_MUL;
            1: return ltrc_pkg::CHAR_ADD;
            2: return ltrc_pkg::CHAR_SUB;
            default: return ltrc_pkg::CHAR_DIV;
        endcase
    endfunction

    task automatic send_random_operand();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            send_symbol(ltrc_pkg::CHAR_ZERO);
            return;
        end
        n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
        repeat (n) begin
            // stray byte, may even cut the expression short
            if ($urandom_range(0, 19) == 0)
                send_symbol(ltrc_pkg::symbol_t'($urandom_range(0, 255)));
            send_symbol(ltrc_pkg::CHAR_ZERO + ltrc_pkg::symbol_t'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_random_expression();
        int terms;
        sender_burst = ($urandom_range(0, 3) == 0);
        terms = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 35) : $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0) send_symbol(pick_operator());
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                send_symbol(pick_operator());
                if ($urandom_range(0, 14) == 0) send_symbol(pick_operator());
            end
            send_random_operand();
        end
        if ($urandom_range(0, 9) == 0) send_symbol(pick_operator());
        send_symbol(ltrc_pkg::CHAR_NEWLINE);
    endtask

    task automatic test_empty_and_ignored();
        send_symbol(ltrc_pkg::CHAR_NEWLINE);
        send_symbol(8'h00);
        send_line(",7.");
        send_symbol(8'hFF);
        send_symbol(ltrc_pkg::CHAR_NEWLINE);
    endtask

    task automatic test_operators_and_div_zero();
        // ends with a negative dividend over zero
        send_line("3*5+4/3-9/0");
        // bare operator with nothing pending, then zero over zero
        send_line("/0");
    endtask

    task automatic test_overflow();
        send_line("9999999999");
        send_line("99999*99999");
    endtask

    // receiver sits idle while the sender keeps pushing short expressions
    task automatic test_backpressure();
        sender_burst = 1'b1;
        hold_off_request = 1'b1;
        repeat (6) send_line("12*3");
    endtask

    task automatic test_random_expressions();
        while (symbols_sent < ITEM_TARGET) send_random_expression();
    endtask

    initial begin
        s_valid          = 1'b0;
        s_symbol         = '0;
        aresetn          = 1'b0;
        mismatches       = 0;
        symbols_sent     = 0;
        sender_burst     = 1'b0;
        hold_off_request = 1'b0;
        clear_expression();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_ignored();
        test_operators_and_div_zero();
        test_overflow();
        test_backpressure();
        test_random_expressions();

        s_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("PASS left_to_right_calculator");
        else
            $display("FAIL left_to_right_calculator");
        $finish;
    end

    initial begin : result_checker
        int stall;
        calc_result_t want;
        m_ready = 1'b0;
        receiver_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 7) == 0) receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 10);
            if (hold_off_request) begin
                stall += PRESSURE_CYCLES;
                hold_off_request = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: value %h code %0d",
                             m_value, m_error_code);
            end else begin
                want = predicted_results.pop_front();
                if (m_value !== want.value || m_error_code !== want.code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value %h code %0d, got value %h code %0d",
                                 want.value, want.code, m_value, m_error_code);
                end
            end
        end
    end

    // no transaction on either side for too long means the block is stuck
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL left_to_right_calculator");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

endmodule

FILE: left_to_right_calculator.f
+incdir+hdl
hdl/ltrc_pkg.sv
hdl/ltrc_dp.sv
hdl/ltrc_ctrl.sv
hdl/left_to_right_calculator.sv
dv/tb.sv
